[rtl/core/multitouch_slot_tracker_unit_defines.svh]
// Assertion macros for the slot tracker.
`ifndef MULTITOUCH_SLOT_TRACKER_UNIT_DEFINES_SVH
`define MULTITOUCH_SLOT_TRACKER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// checked property, switched off while reset is high
`define MTS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked property, also checked across reset
`define MTS_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MTS_ASSERT(label, clk, rst, prop, msg)
`define MTS_ASSERT_NR(label, clk, prop, msg)
`endif

`endif

[rtl/core/mts_pkg.sv]
package mts_pkg;

   localparam int SLOT_COUNT  = 16;
   localparam int SLOT_W      = $clog2(SLOT_COUNT);
   localparam int MAX_RESULTS = 16;
   localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

   localparam int REQ_TDATA_W = 112;
   localparam int REQ_TUSER_W = 5;
   localparam int RSP_TDATA_W = 168;
   localparam int RSP_TUSER_W = 2;

   localparam logic [4:0] TYPE_SYNC   = 5'd0;
   localparam logic [4:0] TYPE_ABS    = 5'd3;
   localparam logic [9:0] CODE_REPORT = 10'h000;
   localparam logic [9:0] CODE_SLOT   = 10'h02f;
   localparam logic [9:0] CODE_TRACK  = 10'h039;
   localparam logic [9:0] CODE_X      = 10'h035;
   localparam logic [9:0] CODE_Y      = 10'h036;

   typedef enum logic [1:0] {
      KIND_DOWN = 2'd0,
      KIND_MOVE = 2'd1,
      KIND_UP   = 2'd2
   } touch_kind_type;

   typedef struct packed {
      touch_kind_type kind;
      logic [3:0]     slot;
      logic [31:0]    x;
      logic [31:0]    y;
      logic [63:0]    stamp;
      logic [31:0]    seq;
   } result_type;

   // scanner to output stage
   typedef struct packed {
      logic push;
      logic flush;
   } outctl_type;

endpackage

[rtl/core/mts_ram.sv]
module mts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read-first: a read of the address being written returns the old word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/mts_ctrl.sv]
module mts_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [4:0]          req_op,
   input  logic [9:0]          req_code,
   input  logic signed [31:0]  req_value,
   input  logic [63:0]         req_time,
   output mts_pkg::outctl_type ctl_out,
   output mts_pkg::result_type result,
   input  logic                out_ok
);
   import mts_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_UPD   = 4'b0010,
      ST_SCAN  = 4'b0100,
      ST_FLUSH = 4'b1000
   } state_type;

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic        active;
      logic        prev_active;
      logic        has_x;
      logic        has_y;
      logic        changed;
   } rec_type;

   localparam int REC_W = $bits(rec_type);

   state_type          state_ff, state_in;
   logic [SLOT_W-1:0]  cur_slot_ff, cur_slot_in;
   logic [SLOT_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [31:0]        seq_ff, seq_in;
   logic [9:0]         code_ff, code_in;
   logic [31:0]        value_ff, value_in;
   logic [63:0]        stamp_ff, stamp_in;
   logic [SLOT_COUNT-1:0] valid_ff, valid_in;
   logic               rd_valid_ff, rd_valid_in;

   logic               wr_en;
   logic [SLOT_W-1:0]  wr_addr;
   logic [SLOT_W-1:0]  rd_addr;
   logic [REC_W-1:0]   rd_data;
   rec_type            rd_rec, wr_rec;
   logic               emit, need_push, stall;
   touch_kind_type     kind;
   logic [SLOT_W-1:0]  sat_slot;

   mts_ram #(.WIDTH(REC_W), .DEPTH(SLOT_COUNT)) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_rec),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      if (req_value[31]) begin
         sat_slot = '0;
      end else if (req_value > 32'(SLOT_COUNT - 1)) begin
         sat_slot = SLOT_W'(SLOT_COUNT - 1);
      end else begin
         sat_slot = req_value[SLOT_W-1:0];
      end
   end

   // a slot never written reads as all zero
   assign rd_rec = rd_valid_ff ? rec_type'(rd_data) : '0;

   always_comb begin
      emit = 1'b0;
      kind = KIND_DOWN;
      if (rd_rec.changed && rd_rec.has_x && rd_rec.has_y) begin
         if (rd_rec.active && !rd_rec.prev_active) begin
            emit = 1'b1;
            kind = KIND_DOWN;
         end else if (rd_rec.active) begin
            emit = 1'b1;
            kind = KIND_MOVE;
         end else if (rd_rec.prev_active) begin
            emit = 1'b1;
            kind = KIND_UP;
         end
      end
      need_push = emit && (count_ff < CNT_W'(MAX_RESULTS));
      stall     = need_push && !out_ok;
   end

   always_comb begin
      result.kind  = kind;
      result.slot  = 4'(idx_ff);
      result.x     = rd_rec.x;
      result.y     = rd_rec.y;
      result.stamp = stamp_ff;
      result.seq   = seq_ff + 32'd1;
   end

   always_comb begin
      state_in      = state_ff;
      cur_slot_in   = cur_slot_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      seq_in        = seq_ff;
      code_in       = code_ff;
      value_in      = value_ff;
      stamp_in      = stamp_ff;
      valid_in      = valid_ff;
      wr_en         = 1'b0;
      wr_addr       = cur_slot_ff;
      wr_rec        = rd_rec;
      rd_addr       = cur_slot_ff;
      ctl_out.push  = 1'b0;
      ctl_out.flush = 1'b0;
      req_tready    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_op == TYPE_ABS && req_code == CODE_SLOT) begin
                  cur_slot_in = sat_slot;
               end else if (req_op == TYPE_ABS && (req_code == CODE_TRACK ||
                            req_code == CODE_X || req_code == CODE_Y)) begin
                  // slot word is read this cycle, merged next cycle
                  code_in  = req_code;
                  value_in = req_value;
                  state_in = ST_UPD;
               end else if (req_op == TYPE_SYNC && req_code == CODE_REPORT) begin
                  stamp_in = req_time;
                  idx_in   = '0;
                  count_in = '0;
                  rd_addr  = '0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_UPD: begin
            wr_en = 1'b1;
            if (code_ff == CODE_TRACK) begin
               wr_rec.active  = !value_ff[31];
               wr_rec.changed = 1'b1;
            end else if (code_ff == CODE_X) begin
               wr_rec.x       = value_ff;
               wr_rec.has_x   = 1'b1;
               wr_rec.changed = 1'b1;
            end else if (code_ff == CODE_Y) begin
               wr_rec.y       = value_ff;
               wr_rec.has_y   = 1'b1;
               wr_rec.changed = 1'b1;
            end
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            ctl_out.push = need_push;
            wr_addr      = idx_ff;
            if (stall) begin
               rd_addr = idx_ff;
            end else begin
               rd_addr            = idx_ff + SLOT_W'(1);
               wr_en              = 1'b1;
               wr_rec.prev_active = rd_rec.active;
               wr_rec.changed     = 1'b0;
               if (need_push) begin
                  count_in = count_ff + CNT_W'(1);
                  seq_in   = seq_ff + 32'd1;
               end
               if (idx_ff == SLOT_W'(SLOT_COUNT - 1)) begin
                  state_in = ST_FLUSH;
               end else begin
                  idx_in = idx_ff + SLOT_W'(1);
               end
            end
         end
         ST_FLUSH: begin
            ctl_out.flush = 1'b1;
            if (out_ok) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
      rd_valid_in = valid_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         cur_slot_ff <= '0;
         idx_ff      <= '0;
         count_ff    <= '0;
         seq_ff      <= '0;
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cur_slot_ff <= cur_slot_in;
         idx_ff      <= idx_in;
         count_ff    <= count_in;
         seq_ff      <= seq_in;
         valid_ff    <= valid_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff  <= code_in;
      value_ff <= value_in;
      stamp_ff <= stamp_in;
   end

endmodule

[rtl/core/mts_out_stage.sv]
module mts_out_stage (
   input  logic                clock,
   input  logic                reset,
   input  mts_pkg::outctl_type ctl_in,
   input  mts_pkg::result_type result,
   output logic                out_ok,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output mts_pkg::result_type rsp_result,
   output logic                rsp_last
);
   import mts_pkg::*;

   // one result is held back until the next one, or the end of the scan,
   // tells whether it is the last of the report
   result_type hold_ff, hold_in;
   logic       hold_valid_ff, hold_valid_in;
   result_type out_ff, out_in;
   logic       out_valid_ff, out_valid_in;
   logic       out_last_ff, out_last_in;
   logic       out_free;

   assign out_free = !out_valid_ff || rsp_tready;
   assign out_ok   = !hold_valid_ff || out_free;

   always_comb begin
      hold_in       = hold_ff;
      hold_valid_in = hold_valid_ff;
      out_in        = out_ff;
      out_last_in   = out_last_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      if (ctl_in.push && out_ok) begin
         if (hold_valid_ff) begin
            out_in       = hold_ff;
            out_last_in  = 1'b0;
            out_valid_in = 1'b1;
         end
         hold_in       = result;
         hold_valid_in = 1'b1;
      end else if (ctl_in.flush && out_ok) begin
         if (hold_valid_ff) begin
            out_in       = hold_ff;
            out_last_in  = 1'b1;
            out_valid_in = 1'b1;
         end
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff     <= hold_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_result = out_ff;
   assign rsp_last   = out_last_ff;

endmodule

[rtl/core/multitouch_slot_tracker_unit.sv]
// Slot select and unknown events are handled while idle; tracking id, X and Y
// need a slot memory read, then a merge and write back.
// A report runs through the accepting cycle, a scan at one slot word read per cycle from
// slot memory, then a flush of the held result; a stalled output holds scan and flush.
// A scanned result is registered in the hold register, then in the output register.
// Reset clears per-slot valid bits (unwritten slots read as zero), current slot and count.
`include "multitouch_slot_tracker_unit_defines.svh"

module multitouch_slot_tracker_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // event_code[9:0], event_value[41:10], receipt_time[105:42], zero pad
   input  logic [mts_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // op[4:0]
   input  logic [mts_pkg::REQ_TUSER_W-1:0]     req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // slot_index[3:0], x_position[35:4], y_position[67:36], stamp_time[131:68],
   // sequence_number[163:132], zero pad
   output logic [mts_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   // touch_kind[1:0]
   output logic [mts_pkg::RSP_TUSER_W-1:0]     rsp_tuser,
   output logic                                rsp_tlast
);
   import mts_pkg::*;

   outctl_type ctl;
   result_type result;
   result_type rsp_result;
   logic       out_ok;
   logic       push_stalled;

   mts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser[4:0]),
      .req_code   (req_tdata[9:0]),
      .req_value  (req_tdata[41:10]),
      .req_time   (req_tdata[105:42]),
      .ctl_out    (ctl),
      .result     (result),
      .out_ok     (out_ok)
   );

   mts_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .ctl_in     (ctl),
      .result     (result),
      .out_ok     (out_ok),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_result (rsp_result),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {4'd0, rsp_result.seq, rsp_result.stamp, rsp_result.y,
                       rsp_result.x, rsp_result.slot};
   assign rsp_tuser = rsp_result.kind;

   assign push_stalled = ctl.push && !out_ok;

   `MTS_ASSERT(a_push_holds, clock, reset, push_stalled |=> ctl.push && $stable(result), "push lost")
   `MTS_ASSERT(a_idle_quiet, clock, reset, req_tready |-> !ctl.push && !ctl.flush, "busy when idle")
   `MTS_ASSERT_NR(a_reset_empty, clock, reset |=> !rsp_tvalid, "result pending after reset")

endmodule
